>>> rtl/tsu_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tsu_pkg
// Shared types and constants for the trigger-sync unit.
// ----------------------------------------------------------------------------
package tsu_pkg;

	localparam int KIND_W   = 3;
	localparam int TIME_W   = 32;
	localparam int REASON_W = 8;
	localparam int INDEX_W  = 3;
	localparam int MASK_W   = 8;
	localparam int RKIND_W  = 2;

	// Number of subscriber slots; slots at or above this are ignored.
	localparam int NUM_SIGNALS = 8;

	// Result queue: one request can produce two results.
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = 2;
	localparam int QCNT_W      = 3;

	typedef enum logic [KIND_W-1:0] {
		KIND_START       = 3'd0,
		KIND_SET_TIMEOUT = 3'd1,
		KIND_TRIGGER     = 3'd2,
		KIND_TICK        = 3'd3,
		KIND_ADD_SIGNAL  = 3'd4,
		KIND_CLEAR       = 3'd5
	} kind_t;

	typedef enum logic [RKIND_W-1:0] {
		RES_DISPATCH = 2'd0,
		RES_REPORT   = 2'd1,
		RES_ERROR    = 2'd2
	} result_kind_t;

	typedef struct packed {
		result_kind_t        kind;
		logic [MASK_W-1:0]   mask;
		logic                armed_flag;
		logic [REASON_W-1:0] reason;
		logic [TIME_W-1:0]   clock;
		logic                last;
	} result_t;

	// A deadline counts as reached when the wrapped distance from it is
	// less than half the counter range.
	function automatic logic reached(input logic [TIME_W-1:0] now,
	                                 input logic [TIME_W-1:0] deadline);
		logic [TIME_W-1:0] diff;
		diff = now - deadline;
		return ~diff[TIME_W-1];
	endfunction

endpackage
`default_nettype wire

>>> rtl/trigger_sync_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// trigger_sync_unit
// One trigger-sync instance: arming, expire timeout, subscriber dispatch and
// periodic state reports driven by time ticks.
// ----------------------------------------------------------------------------
//  Channel   Handshake               Payload
//  request   req_valid / req_stall   kind, time_value, period, reason_in,
//                                    signal_index
//  result    rsp_valid / rsp_stall   result_kind, signal_mask, can_trigger_out,
//                                    reason_out, clock_out, last
//
//  A request is registered in the request stage and processed there once the queue
//  has room; its results enter a four-entry result queue. The first result passes
//  through the request stage and the result queue before it reaches the outputs.
//  One request is taken per cycle while the queue has room for two results.
//  A request that yields two results writes both into the queue; they drain one at a time.
//  A stall on the result side fills the queue, then holds the request stage.
//  The asynchronous reset clears all unit state and empties both stages.
// ----------------------------------------------------------------------------
module trigger_sync_unit (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                req_valid,
	output logic                               req_stall,
	input  wire  [tsu_pkg::KIND_W-1:0]         kind,
	input  wire  [tsu_pkg::TIME_W-1:0]         time_value,
	input  wire  [tsu_pkg::TIME_W-1:0]         period,
	input  wire  [tsu_pkg::REASON_W-1:0]       reason_in,
	input  wire  [tsu_pkg::INDEX_W-1:0]        signal_index,
	output logic                               rsp_valid,
	input  wire                                rsp_stall,
	output logic [tsu_pkg::RKIND_W-1:0]        result_kind,
	output logic [tsu_pkg::MASK_W-1:0]         signal_mask,
	output logic                               can_trigger_out,
	output logic [tsu_pkg::REASON_W-1:0]       reason_out,
	output logic [tsu_pkg::TIME_W-1:0]         clock_out,
	output logic                               last
);

	// Request stage
	logic                             valid_s1;
	logic [tsu_pkg::KIND_W-1:0]       kind_s1;
	logic [tsu_pkg::TIME_W-1:0]       time_s1;
	logic [tsu_pkg::TIME_W-1:0]       period_s1;
	logic [tsu_pkg::REASON_W-1:0]     reason_s1;
	logic [tsu_pkg::INDEX_W-1:0]      index_s1;

	// Unit state
	logic                             armed_q;
	logic                             pending_q;
	logic [tsu_pkg::REASON_W-1:0]     latched_q;
	logic [tsu_pkg::REASON_W-1:0]     exp_reason_q;
	logic [tsu_pkg::TIME_W-1:0]       interval_q;
	logic [tsu_pkg::TIME_W-1:0]       rep_dl_q;
	logic                             rep_on_q;
	logic [tsu_pkg::TIME_W-1:0]       exp_dl_q;
	logic                             exp_on_q;
	logic [tsu_pkg::MASK_W-1:0]       subs_q;

	logic                             armed_d;
	logic                             pending_d;
	logic [tsu_pkg::REASON_W-1:0]     latched_d;
	logic [tsu_pkg::REASON_W-1:0]     exp_reason_d;
	logic [tsu_pkg::TIME_W-1:0]       interval_d;
	logic [tsu_pkg::TIME_W-1:0]       rep_dl_d;
	logic                             rep_on_d;
	logic [tsu_pkg::TIME_W-1:0]       exp_dl_d;
	logic                             exp_on_d;
	logic [tsu_pkg::MASK_W-1:0]       subs_d;

	// Result queue
	tsu_pkg::result_t                 queue_q [tsu_pkg::QUEUE_DEPTH];
	logic [tsu_pkg::QPTR_W-1:0]       wr_ptr_q;
	logic [tsu_pkg::QPTR_W-1:0]       rd_ptr_q;
	logic [tsu_pkg::QCNT_W-1:0]       count_q;

	logic                             room;
	logic                             accept;
	logic                             step_en;
	logic                             pop;
	logic                             has_disp;
	logic                             has_other;
	tsu_pkg::result_t                 disp_res;
	tsu_pkg::result_t                 other_res;
	tsu_pkg::result_t                 slot0;
	tsu_pkg::result_t                 slot1;
	logic [1:0]                       push_n;
	tsu_pkg::result_t                 head;

	assign room      = count_q <= tsu_pkg::QCNT_W'(tsu_pkg::QUEUE_DEPTH - 2);
	assign req_stall = valid_s1 & ~room;
	assign accept    = req_valid & ~req_stall;
	assign step_en   = valid_s1 & room;
	assign pop       = rsp_valid & ~rsp_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (step_en) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_s1   <= kind;
			time_s1   <= time_value;
			period_s1 <= period;
			reason_s1 <= reason_in;
			index_s1  <= signal_index;
		end
	end

	always_comb begin
		logic                         exp_fire;
		logic                         rep_fire;
		logic [tsu_pkg::MASK_W-1:0]   bit_sel;

		armed_d      = armed_q;
		pending_d    = pending_q;
		latched_d    = latched_q;
		exp_reason_d = exp_reason_q;
		interval_d   = interval_q;
		rep_dl_d     = rep_dl_q;
		rep_on_d     = rep_on_q;
		exp_dl_d     = exp_dl_q;
		exp_on_d     = exp_on_q;
		subs_d       = subs_q;
		has_disp     = 1'b0;
		has_other    = 1'b0;
		exp_fire     = exp_on_q & tsu_pkg::reached(time_s1, exp_dl_q);
		rep_fire     = rep_on_q & tsu_pkg::reached(time_s1, rep_dl_q);
		bit_sel      = tsu_pkg::MASK_W'(1) << index_s1;

		disp_res = '{kind: tsu_pkg::RES_DISPATCH, mask: subs_q, armed_flag: 1'b0,
		             reason: reason_s1, clock: '0, last: 1'b0};
		other_res = '{kind: tsu_pkg::RES_REPORT, mask: '0, armed_flag: 1'b0,
		              reason: '0, clock: '0, last: 1'b1};

		unique case (kind_s1)
			tsu_pkg::KIND_START: begin
				armed_d      = 1'b1;
				pending_d    = 1'b0;
				latched_d    = '0;
				exp_reason_d = reason_s1;
				interval_d   = period_s1;
				rep_dl_d     = time_s1;
				rep_on_d     = period_s1 != '0;
				exp_on_d     = 1'b0;
				subs_d       = '0;
			end
			tsu_pkg::KIND_SET_TIMEOUT: begin
				if (armed_q) begin
					exp_dl_d = time_s1;
					exp_on_d = 1'b1;
				end
			end
			tsu_pkg::KIND_TRIGGER: begin
				if (armed_q) begin
					latched_d = reason_s1;
					subs_d    = '0;
					has_disp  = subs_q != '0;
				end
				armed_d          = 1'b0;
				pending_d        = 1'b0;
				rep_on_d         = 1'b0;
				exp_on_d         = 1'b0;
				has_other        = 1'b1;
				other_res.reason = armed_q ? reason_s1 : latched_q;
			end
			tsu_pkg::KIND_TICK: begin
				if (exp_fire) begin
					exp_on_d = 1'b0;
					if (armed_q) begin
						latched_d       = exp_reason_q;
						armed_d         = 1'b0;
						subs_d          = '0;
						has_disp        = subs_q != '0;
						disp_res.reason = exp_reason_q;
					end
				end
				if (rep_fire) begin
					rep_dl_d = rep_dl_q + interval_q;
				end
				// Expiry of an armed unit also produces a report in this tick.
				has_other = pending_q | rep_fire | (exp_fire & armed_q);
				pending_d = 1'b0;
				other_res.armed_flag = armed_d;
				other_res.reason     = latched_d;
				other_res.clock      = time_s1;
			end
			tsu_pkg::KIND_ADD_SIGNAL: begin
				if (int'(index_s1) < tsu_pkg::NUM_SIGNALS) begin
					if ((subs_q & bit_sel) != '0) begin
						has_other      = 1'b1;
						other_res.kind = tsu_pkg::RES_ERROR;
						other_res.mask = bit_sel;
					end else begin
						subs_d = subs_q | bit_sel;
					end
				end
			end
			tsu_pkg::KIND_CLEAR: begin
				armed_d      = 1'b0;
				pending_d    = 1'b0;
				latched_d    = '0;
				exp_reason_d = '0;
				rep_on_d     = 1'b0;
				exp_on_d     = 1'b0;
				subs_d       = '0;
			end
			default: begin
			end
		endcase

		if (has_disp) begin
			slot0 = disp_res;
			slot0.last = ~has_other;
		end else begin
			slot0 = other_res;
		end
		slot1  = other_res;
		push_n = 2'(has_disp) + 2'(has_other);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q      <= 1'b0;
			pending_q    <= 1'b0;
			latched_q    <= '0;
			exp_reason_q <= '0;
			interval_q   <= '0;
			rep_dl_q     <= '0;
			rep_on_q     <= 1'b0;
			exp_dl_q     <= '0;
			exp_on_q     <= 1'b0;
			subs_q       <= '0;
		end else if (step_en) begin
			armed_q      <= armed_d;
			pending_q    <= pending_d;
			latched_q    <= latched_d;
			exp_reason_q <= exp_reason_d;
			interval_q   <= interval_d;
			rep_dl_q     <= rep_dl_d;
			rep_on_q     <= rep_on_d;
			exp_dl_q     <= exp_dl_d;
			exp_on_q     <= exp_on_d;
			subs_q       <= subs_d;
		end
	end

	always_ff @(posedge clk) begin
		if (step_en && push_n != 2'd0) begin
			queue_q[wr_ptr_q] <= slot0;
			if (push_n == 2'd2) begin
				queue_q[wr_ptr_q + tsu_pkg::QPTR_W'(1)] <= slot1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (step_en) begin
				wr_ptr_q <= wr_ptr_q + tsu_pkg::QPTR_W'(push_n);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + tsu_pkg::QPTR_W'(1);
			end
			count_q <= count_q + (step_en ? tsu_pkg::QCNT_W'(push_n) : '0)
			           - tsu_pkg::QCNT_W'(pop);
		end
	end

	assign head            = queue_q[rd_ptr_q];
	assign rsp_valid       = count_q != '0;
	assign result_kind     = head.kind;
	assign signal_mask     = head.mask;
	assign can_trigger_out = head.armed_flag;
	assign reason_out      = head.reason;
	assign clock_out       = head.clock;
	assign last            = head.last;

endmodule
`default_nettype wire

>>> tb/trigger_sync_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// trigger_sync_unit_tb
// Self-checking bench for the trigger-sync unit. A bit-accurate predictor
// runs beside the block on every accepted request. Each result is compared
// field by field with the oldest predicted one. Directed cases cover idle-unit
// behavior, dispatch, expiry with wrapping deadlines and periodic reports.
// Random arm/trigger sessions and noise follow, with random gaps and stalls
// on both channels.
// ----------------------------------------------------------------------------
module trigger_sync_unit_tb;

	localparam int CYCLE_LIMIT = 500000;
	localparam int RANDOM_REQUESTS = 450;
	localparam logic [tsu_pkg::KIND_W-1:0] KIND_UNUSED_6 = 3'd6;
	localparam logic [tsu_pkg::KIND_W-1:0] KIND_UNUSED_7 = 3'd7;

	logic                         clk;
	logic                         arst_n;
	logic                         req_valid;
	logic                         req_stall;
	logic [tsu_pkg::KIND_W-1:0]   kind;
	logic [tsu_pkg::TIME_W-1:0]   time_value;
	logic [tsu_pkg::TIME_W-1:0]   period;
	logic [tsu_pkg::REASON_W-1:0] reason_in;
	logic [tsu_pkg::INDEX_W-1:0]  signal_index;
	logic                         rsp_valid;
	logic                         rsp_stall;
	logic [tsu_pkg::RKIND_W-1:0]  result_kind;
	logic [tsu_pkg::MASK_W-1:0]   signal_mask;
	logic                         can_trigger_out;
	logic [tsu_pkg::REASON_W-1:0] reason_out;
	logic [tsu_pkg::TIME_W-1:0]   clock_out;
	logic                         last;

	trigger_sync_unit u_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.req_valid       (req_valid),
		.req_stall       (req_stall),
		.kind            (kind),
		.time_value      (time_value),
		.period          (period),
		.reason_in       (reason_in),
		.signal_index    (signal_index),
		.rsp_valid       (rsp_valid),
		.rsp_stall       (rsp_stall),
		.result_kind     (result_kind),
		.signal_mask     (signal_mask),
		.can_trigger_out (can_trigger_out),
		.reason_out      (reason_out),
		.clock_out       (clock_out),
		.last            (last)
	);

	// Predicted state of the unit.
	logic                         unit_armed;
	logic                         report_owed;
	logic [tsu_pkg::REASON_W-1:0] held_reason;
	logic [tsu_pkg::REASON_W-1:0] expiry_reason;
	logic [tsu_pkg::TIME_W-1:0]   report_step;
	logic [tsu_pkg::TIME_W-1:0]   report_at;
	logic                         report_running;
	logic [tsu_pkg::TIME_W-1:0]   expiry_at;
	logic                         expiry_running;
	logic [tsu_pkg::MASK_W-1:0]   subscriber_bits;

	tsu_pkg::result_t sync_results_due[$];
	tsu_pkg::result_t step_results[$];

	int  mismatches;
	int  accepted_count;
	int  cycle_count;
	bit  steady_flow;
	logic [tsu_pkg::TIME_W-1:0] sim_now;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("%0t: timeout with %0d results outstanding", $time, sync_results_due.size());
		$display("CHECKS FAILED");
		$finish;
	end

	function automatic logic deadline_passed(input logic [tsu_pkg::TIME_W-1:0] now,
	                                         input logic [tsu_pkg::TIME_W-1:0] deadline);
		logic [tsu_pkg::TIME_W-1:0] gap;
		gap = now - deadline;
		return gap < 32'h8000_0000;
	endfunction

	function automatic void queue_sync_result(input tsu_pkg::result_kind_t k,
	                                          input logic [tsu_pkg::MASK_W-1:0] mask,
	                                          input logic can,
	                                          input logic [tsu_pkg::REASON_W-1:0] why,
	                                          input logic [tsu_pkg::TIME_W-1:0] stamp);
		tsu_pkg::result_t r;
		r.kind       = k;
		r.mask       = mask;
		r.armed_flag = can;
		r.reason     = why;
		r.clock      = stamp;
		r.last       = 1'b0;
		step_results.push_back(r);
	endfunction

	function automatic void clear_sync_state();
		unit_armed      = 1'b0;
		report_owed     = 1'b0;
		held_reason     = '0;
		expiry_reason   = '0;
		report_running  = 1'b0;
		expiry_running  = 1'b0;
		subscriber_bits = '0;
	endfunction

	// The first trigger after arming latches its reason and hands out the mask.
	function automatic void fire_trigger(input logic [tsu_pkg::REASON_W-1:0] why);
		logic [tsu_pkg::MASK_W-1:0] mask;
		if (!unit_armed)
			return;
		held_reason     = why;
		unit_armed      = 1'b0;
		report_owed     = 1'b1;
		mask            = subscriber_bits;
		subscriber_bits = '0;
		if (mask != '0)
			queue_sync_result(tsu_pkg::RES_DISPATCH, mask, 1'b0, why, '0);
	endfunction

	function automatic void advance_sync_unit(input logic [tsu_pkg::KIND_W-1:0] k,
	                                          input logic [tsu_pkg::TIME_W-1:0] tv,
	                                          input logic [tsu_pkg::TIME_W-1:0] per,
	                                          input logic [tsu_pkg::REASON_W-1:0] rin,
	                                          input logic [tsu_pkg::INDEX_W-1:0] idx);
		logic [tsu_pkg::MASK_W-1:0] slot_bit;
		step_results.delete();
		slot_bit = tsu_pkg::MASK_W'(1) << idx;
		case (k)
			tsu_pkg::KIND_START: begin
				clear_sync_state();
				unit_armed     = 1'b1;
				report_at      = tv;
				report_step    = per;
				report_running = (per != '0);
				expiry_reason  = rin;
			end
			tsu_pkg::KIND_SET_TIMEOUT: begin
				if (unit_armed) begin
					expiry_at      = tv;
					expiry_running = 1'b1;
				end
			end
			tsu_pkg::KIND_TRIGGER: begin
				fire_trigger(rin);
				report_running = 1'b0;
				expiry_running = 1'b0;
				unit_armed     = 1'b0;
				report_owed    = 1'b0;
				queue_sync_result(tsu_pkg::RES_REPORT, '0, 1'b0, held_reason, '0);
			end
			tsu_pkg::KIND_TICK: begin
				if (expiry_running && deadline_passed(tv, expiry_at)) begin
					expiry_running = 1'b0;
					fire_trigger(expiry_reason);
				end
				if (report_running && deadline_passed(tv, report_at)) begin
					report_owed = 1'b1;
					report_at   = report_at + report_step;
				end
				if (report_owed) begin
					report_owed = 1'b0;
					queue_sync_result(tsu_pkg::RES_REPORT, '0, unit_armed, held_reason, tv);
				end
			end
			tsu_pkg::KIND_ADD_SIGNAL: begin
				if (int'(idx) < tsu_pkg::NUM_SIGNALS) begin
					if ((subscriber_bits & slot_bit) != '0)
						queue_sync_result(tsu_pkg::RES_ERROR, slot_bit, 1'b0, '0, '0);
					else
						subscriber_bits = subscriber_bits | slot_bit;
				end
			end
			tsu_pkg::KIND_CLEAR: begin
				clear_sync_state();
			end
			default: begin
			end
		endcase
		if (step_results.size() > 0)
			step_results[step_results.size()-1].last = 1'b1;
		foreach (step_results[i])
			sync_results_due.push_back(step_results[i]);
	endfunction

	task automatic send_request(input logic [tsu_pkg::KIND_W-1:0] k,
	                            input logic [tsu_pkg::TIME_W-1:0] tv,
	                            input logic [tsu_pkg::TIME_W-1:0] per,
	                            input logic [tsu_pkg::REASON_W-1:0] rin,
	                            input logic [tsu_pkg::INDEX_W-1:0] idx);
		int gap;
		gap = steady_flow ? 0 : int'($urandom_range(0, 18));
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid    <= 1'b1;
		kind         <= k;
		time_value   <= tv;
		period       <= per;
		reason_in    <= rin;
		signal_index <= idx;
		do @(posedge clk); while (req_stall);
		advance_sync_unit(k, tv, per, rin, idx);
		if (k <= tsu_pkg::KIND_CLEAR)
			accepted_count++;
	endtask

	task automatic compare_field(input string name, input logic [31:0] want,
	                             input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin : result_check
		tsu_pkg::result_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (sync_results_due.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual kind %0d mask 0x%0h",
				         $time, result_kind, signal_mask);
				mismatches++;
			end else begin
				want = sync_results_due.pop_front();
				compare_field("result_kind", 32'(want.kind), 32'(result_kind));
				compare_field("signal_mask", 32'(want.mask), 32'(signal_mask));
				compare_field("can_trigger_out", 32'(want.armed_flag), 32'(can_trigger_out));
				compare_field("reason_out", 32'(want.reason), 32'(reason_out));
				compare_field("clock_out", want.clock, clock_out);
				compare_field("last", 32'(want.last), 32'(last));
			end
		end
	end

	// Result side: hold off a random number of cycles before each result.
	initial begin : result_drain
		int hold;
		rsp_stall <= 1'b0;
		while (arst_n !== 1'b1) @(posedge clk);
		forever begin
			hold = steady_flow ? 0 : int'($urandom_range(0, 18));
			if (hold > 0) begin
				rsp_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			rsp_stall <= 1'b0;
			do @(posedge clk); while (!(rsp_valid && !rsp_stall));
		end
	end

	task automatic test_idle_unit();
		send_request(tsu_pkg::KIND_TICK, '0, '0, '0, '0);
		send_request(tsu_pkg::KIND_TRIGGER, '0, '0, 8'h5A, '0);
		send_request(tsu_pkg::KIND_SET_TIMEOUT, '0, '0, '0, '0);
		send_request(tsu_pkg::KIND_TICK, '0, '0, '0, '0);
		send_request(KIND_UNUSED_6, '1, '1, '1, '1);
		send_request(KIND_UNUSED_7, '1, '1, '1, '1);
		send_request(tsu_pkg::KIND_ADD_SIGNAL, '0, '0, '0, 3'd0);
		send_request(tsu_pkg::KIND_CLEAR, '0, '0, '0, '0);
	endtask

	task automatic test_subscriber_dispatch();
		send_request(tsu_pkg::KIND_START, '0, '0, 8'hFF, '0);
		send_request(tsu_pkg::KIND_ADD_SIGNAL, '0, '0, '0, 3'd0);
		send_request(tsu_pkg::KIND_ADD_SIGNAL, '0, '0, '0, 3'd7);
		// The slot is taken, so this one must come back as an error.
		send_request(tsu_pkg::KIND_ADD_SIGNAL, '0, '0, '0, 3'd7);
		send_request(tsu_pkg::KIND_TRIGGER, '0, '0, 8'hA5, '0);
		send_request(tsu_pkg::KIND_TRIGGER, '0, '0, 8'h00, '0);
	endtask

	task automatic test_expire_timeout();
		send_request(tsu_pkg::KIND_START, '0, '0, 8'h3C, '0);
		send_request(tsu_pkg::KIND_ADD_SIGNAL, '0, '0, '0, 3'd3);
		send_request(tsu_pkg::KIND_SET_TIMEOUT, 32'hFFFF_FFF0, '0, '0, '0);
		send_request(tsu_pkg::KIND_TICK, 32'hFFFF_FFEF, '0, '0, '0);
		// The deadline is reached across the wrap of the time counter.
		send_request(tsu_pkg::KIND_TICK, 32'h0000_0005, '0, '0, '0);
		send_request(tsu_pkg::KIND_TICK, 32'h0000_0006, '0, '0, '0);
		// Expiry with nobody subscribed gives a report but no dispatch.
		send_request(tsu_pkg::KIND_START, '1, '0, '0, '0);
		send_request(tsu_pkg::KIND_SET_TIMEOUT, 32'h0000_0010, '0, '0, '0);
		send_request(tsu_pkg::KIND_TICK, 32'h0000_0010, '0, '0, '0);
	endtask

	task automatic test_periodic_reports();
		send_request(tsu_pkg::KIND_START, 32'h8000_0000, '1, 8'h11, '0);
		send_request(tsu_pkg::KIND_TICK, 32'h7FFF_FFFF, '0, '0, '0);
		send_request(tsu_pkg::KIND_TICK, 32'h8000_0000, '0, '0, '0);
		send_request(tsu_pkg::KIND_TICK, 32'h8000_0000, '0, '0, '0);
		send_request(tsu_pkg::KIND_CLEAR, '0, '0, '0, '0);
		send_request(tsu_pkg::KIND_TICK, 32'h8000_0001, '0, '0, '0);
	endtask

	// Mostly well-formed sessions: start, subscribe, set a timeout and let
	// time run, ending by trigger, expiry or clear. Some raw noise mixed in.
	task automatic test_random_sessions();
		int goal;
		int steps;
		logic [tsu_pkg::TIME_W-1:0] per;
		goal = accepted_count + RANDOM_REQUESTS;
		sim_now = $urandom;
		while (accepted_count < goal) begin
			steady_flow = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 9) < 2) begin
				send_request(tsu_pkg::KIND_W'($urandom_range(0, 7)), $urandom, $urandom,
				             tsu_pkg::REASON_W'($urandom), tsu_pkg::INDEX_W'($urandom));
			end else begin
				case ($urandom_range(0, 9))
					0: per = '0;
					1: per = $urandom;
					default: per = $urandom_range(1, 40);
				endcase
				send_request(tsu_pkg::KIND_START, sim_now + $urandom_range(0, 30), per,
				             tsu_pkg::REASON_W'($urandom_range(0, 255)), '0);
				steps = int'($urandom_range(4, 20));
				repeat (steps) begin
					case ($urandom_range(0, 19))
						0, 1, 2, 3, 4, 5, 6, 7, 8: begin
							if ($urandom_range(0, 39) == 0)
								sim_now = sim_now + 32'h7FFF_FFF0 + $urandom_range(0, 40);
							else
								sim_now = sim_now + $urandom_range(0, 25);
							send_request(tsu_pkg::KIND_TICK, sim_now, $urandom,
							             tsu_pkg::REASON_W'($urandom),
							             tsu_pkg::INDEX_W'($urandom));
						end
						9, 10, 11, 12, 13:
							send_request(tsu_pkg::KIND_ADD_SIGNAL, $urandom, $urandom,
							             tsu_pkg::REASON_W'($urandom),
							             tsu_pkg::INDEX_W'($urandom_range(0, 7)));
						14, 15: begin
							if ($urandom_range(0, 7) == 0)
								send_request(tsu_pkg::KIND_SET_TIMEOUT, $urandom, $urandom,
								             tsu_pkg::REASON_W'($urandom),
								             tsu_pkg::INDEX_W'($urandom));
							else
								send_request(tsu_pkg::KIND_SET_TIMEOUT,
								             sim_now + $urandom_range(0, 60), $urandom,
								             tsu_pkg::REASON_W'($urandom),
								             tsu_pkg::INDEX_W'($urandom));
						end
						16, 17:
							send_request(tsu_pkg::KIND_TRIGGER, $urandom, $urandom,
							             tsu_pkg::REASON_W'($urandom_range(0, 255)),
							             tsu_pkg::INDEX_W'($urandom));
						18:
							send_request(tsu_pkg::KIND_CLEAR, $urandom, $urandom,
							             tsu_pkg::REASON_W'($urandom),
							             tsu_pkg::INDEX_W'($urandom));
						default:
							send_request(tsu_pkg::KIND_START, sim_now, $urandom_range(0, 20),
							             tsu_pkg::REASON_W'($urandom_range(0, 255)),
							             tsu_pkg::INDEX_W'($urandom));
					endcase
				end
			end
		end
		steady_flow = 1'b0;
	endtask

	initial begin
		mismatches     = 0;
		accepted_count = 0;
		steady_flow    = 1'b0;
		clear_sync_state();
		report_step = '0;
		report_at   = '0;
		expiry_at   = '0;
		arst_n       <= 1'b0;
		req_valid    <= 1'b0;
		kind         <= '0;
		time_value   <= '0;
		period       <= '0;
		reason_in    <= '0;
		signal_index <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_idle_unit();
		test_subscriber_dispatch();
		test_expire_timeout();
		test_periodic_reports();
		test_random_sessions();
		req_valid <= 1'b0;
		while (sync_results_due.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

>>> trigger_sync_unit.f
rtl/tsu_pkg.sv
rtl/trigger_sync_unit.sv
tb/trigger_sync_unit_tb.sv
